// ----- sv/pct_pkg.sv -----
`timescale 1ns / 1ps

package pct_pkg;

  localparam int unsigned DEF_ENTRY_COUNT = 256;
  localparam int unsigned IDX_IN_W        = 8;
  localparam int unsigned CYC_W           = 64;
  localparam int unsigned DIV_CNT_W       = $clog2(CYC_W);

  typedef enum logic [1:0] {
    FUNC_RECORD = 2'd0,
    FUNC_ALLOC  = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef struct packed {
    logic [CYC_W-1:0] calls;
    logic [CYC_W-1:0] sum;
    logic [CYC_W-1:0] least;
    logic [CYC_W-1:0] most;
    logic [CYC_W-1:0] latest;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    calls:  '0,
    sum:    '0,
    least:  '1,
    most:   '0,
    latest: '0
  };

  typedef struct packed {
    logic [IDX_IN_W-1:0] assigned_index;
    logic                entry_used;
    logic [CYC_W-1:0]    calls;
    logic [CYC_W-1:0]    cycle_sum;
    logic [CYC_W-1:0]    fewest_cycles;
    logic [CYC_W-1:0]    most_cycles;
    logic [CYC_W-1:0]    latest_cycles;
    logic [CYC_W-1:0]    mean_cycles;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic rd_en;       // item accepted: latch payload, read entry
    logic rec_wr;      // write back updated entry
    logic div_start;
    logic load_out;
    logic alloc_step;
    logic clr_start;
    logic clr_run;
  } pct_cmd_t;

  // datapath -> controller
  typedef struct packed {
    func_e func;
    logic  calls_zero;
    logic  div_busy;
    logic  clr_last;
  } pct_stat_t;

endpackage

// ----- sv/pct_if.sv -----
`timescale 1ns / 1ps

interface pct_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  entry_index;
  logic [63:0] measured_cycles;

  modport source (output valid, output func, output entry_index, output measured_cycles,
                  input ready);
  modport sink   (input valid, input func, input entry_index, input measured_cycles,
                  output ready);
endinterface

interface pct_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  assigned_index;
  logic        entry_used;
  logic [63:0] calls;
  logic [63:0] cycle_sum;
  logic [63:0] fewest_cycles;
  logic [63:0] most_cycles;
  logic [63:0] latest_cycles;
  logic [63:0] mean_cycles;

  modport source (output valid, output assigned_index, output entry_used, output calls,
                  output cycle_sum, output fewest_cycles, output most_cycles,
                  output latest_cycles, output mean_cycles, input ready);
  modport sink   (input valid, input assigned_index, input entry_used, input calls,
                  input cycle_sum, input fewest_cycles, input most_cycles,
                  input latest_cycles, input mean_cycles, output ready);
endinterface

// ----- sv/pct_dp.sv -----
`timescale 1ns / 1ps

module pct_dp #(
  parameter int unsigned ENTRY_COUNT = pct_pkg::DEF_ENTRY_COUNT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pct_pkg::pct_cmd_t           cmd_i,
  output pct_pkg::pct_stat_t          stat_o,
  input  logic [1:0]                  func_i,
  input  logic [pct_pkg::IDX_IN_W-1:0] entry_index_i,
  input  logic [pct_pkg::CYC_W-1:0]   cycles_i,
  output pct_pkg::result_t            res_o
);
  import pct_pkg::*;

  localparam int unsigned IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int unsigned AW    = $clog2(ENTRY_COUNT + 1);
  localparam int unsigned RED_W = 21;

  entry_t mem [ENTRY_COUNT];

  func_e            func_q;
  logic [IDX_W-1:0] idx_q;
  logic [CYC_W-1:0] cyc_q;
  entry_t           rd_q;
  logic [IDX_W-1:0] idx_red;
  logic [IDX_W-1:0] clr_addr_q;
  logic [AW-1:0]    alloc_q;
  logic [AW-1:0]    given;
  logic [31:0]      given_ext;
  entry_t           upd;
  result_t          res_d;
  result_t          out_q;

  logic [CYC_W-1:0]     rem_q;
  logic [CYC_W-1:0]     quo_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic                 div_busy_q;
  logic [CYC_W+1:0]     div_diff;

  // index modulo ENTRY_COUNT: restoring reduction, one shifted compare per bit
  always_comb begin
    logic [RED_W-1:0] v;
    logic [RED_W-1:0] m;
    v = RED_W'(entry_index_i);
    for (int k = IDX_IN_W - 1; k >= 0; k--) begin
      m = RED_W'(ENTRY_COUNT) << k;
      if (v >= m) begin
        v = v - m;
      end
    end
    idx_red = v[IDX_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      func_q <= func_e'(func_i);
      idx_q  <= idx_red;
      cyc_q  <= cycles_i;
      rd_q   <= mem[idx_red];
    end
    if (cmd_i.clr_run) begin
      mem[clr_addr_q] <= ENTRY_RESET;
    end else if (cmd_i.rec_wr) begin
      mem[idx_q] <= upd;
    end
  end

  always_comb begin
    upd.calls  = rd_q.calls + CYC_W'(1);
    upd.sum    = rd_q.sum + cyc_q;
    upd.latest = cyc_q;
    upd.least  = (cyc_q < rd_q.least) ? cyc_q : rd_q.least;
    upd.most   = (cyc_q > rd_q.most) ? cyc_q : rd_q.most;
  end

  // clear sweep and allocator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      alloc_q    <= '0;
    end else begin
      if (cmd_i.clr_start) begin
        clr_addr_q <= '0;
        alloc_q    <= '0;
      end else begin
        if (cmd_i.clr_run) begin
          clr_addr_q <= clr_addr_q + IDX_W'(1);
        end
        if (cmd_i.alloc_step && (alloc_q < AW'(ENTRY_COUNT))) begin
          alloc_q <= alloc_q + AW'(1);
        end
      end
    end
  end

  assign given     = (alloc_q >= AW'(ENTRY_COUNT)) ? AW'(ENTRY_COUNT - 1) : alloc_q;
  assign given_ext = 32'(given);

  // restoring divider, one quotient bit per cycle; sum shifts out of quo_q
  assign div_diff = {1'b0, rem_q, quo_q[CYC_W-1]} - {2'b00, rd_q.calls};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      div_busy_q <= 1'b1;
      div_cnt_q  <= '0;
    end else if (div_busy_q) begin
      div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      if (div_cnt_q == DIV_CNT_W'(CYC_W - 1)) begin
        div_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= rd_q.sum;
    end else if (div_busy_q) begin
      if (!div_diff[CYC_W+1]) begin
        rem_q <= div_diff[CYC_W-1:0];
        quo_q <= {quo_q[CYC_W-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[CYC_W-2:0], quo_q[CYC_W-1]};
        quo_q <= {quo_q[CYC_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    res_d = '0;
    case (func_q)
      FUNC_ALLOC: begin
        res_d.assigned_index = given_ext[IDX_IN_W-1:0];
      end
      FUNC_READ: begin
        res_d.entry_used    = (AW'(idx_q) < alloc_q) && (rd_q.calls != '0);
        res_d.calls         = rd_q.calls;
        res_d.cycle_sum     = rd_q.sum;
        res_d.fewest_cycles = rd_q.least;
        res_d.most_cycles   = rd_q.most;
        res_d.latest_cycles = rd_q.latest;
        res_d.mean_cycles   = (rd_q.calls != '0) ? quo_q : '0;
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= res_d;
    end
  end

  assign res_o = out_q;

  assign stat_o.func       = func_q;
  assign stat_o.calls_zero = (rd_q.calls == '0);
  assign stat_o.div_busy   = div_busy_q;
  assign stat_o.clr_last   = (clr_addr_q == IDX_W'(ENTRY_COUNT - 1));

endmodule

// ----- sv/pct_ctrl.sv -----
`timescale 1ns / 1ps

module pct_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  pct_pkg::pct_stat_t stat_i,
  output pct_pkg::pct_cmd_t  cmd_o
);
  import pct_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_CLEAR,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        cmd_o.clr_run = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.rd_en = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (stat_i.func)
          FUNC_READ: begin
            if (!stat_i.calls_zero) begin
              cmd_o.div_start = 1'b1;
              state_d         = ST_DIV;
            end else begin
              state_d = ST_FINISH;
            end
          end
          FUNC_CLEAR: begin
            cmd_o.clr_start = 1'b1;
            state_d         = ST_CLEAR;
          end
          FUNC_RECORD: begin
            cmd_o.rec_wr = 1'b1;
            state_d      = ST_FINISH;
          end
          default: begin
            state_d = ST_FINISH;
          end
        endcase
      end
      ST_DIV: begin
        if (!stat_i.div_busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_run = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_d = ST_FINISH;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // hand the result to the output register as soon as it is free
    if (state_d == ST_FINISH && out_free &&
        !(state_q == ST_EXEC && stat_i.func == FUNC_READ && !stat_i.calls_zero) &&
        !(state_q == ST_EXEC && stat_i.func == FUNC_CLEAR)) begin
      cmd_o.load_out   = 1'b1;
      cmd_o.alloc_step = (stat_i.func == FUNC_ALLOC);
      state_d          = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/perf_counter_table_unit.sv -----
`timescale 1ns / 1ps

// Bank of ENTRY_COUNT measurement counters (calls, wrapping sum, min, max, latest).
// in_i carries one item: func (record, allocate, read, clear all), entry_index
// (taken modulo ENTRY_COUNT) and measured_cycles. out_o returns exactly one result
// item per input item; fields that do not apply to the operation are zero.
// Steps from acceptance to the result entering the output register:
//   record, allocate, read of an entry with no calls: entry read on acceptance, then loaded
//   read with calls: the 1-bit-per-cycle 64-bit divider for the mean runs in DIV first
//   clear all: CLEAR rewrites the table first, one entry rewritten per cycle
// One item is in flight at a time; in_i.ready is high only while idle.
// The output register holds a finished result while the receiver stalls; the
// block still accepts and processes the next item, and waits at its end until
// the register is free.
// After reset the table is swept to its reset values (min all ones, rest zero),
// while in_i.ready stays low; the allocator restarts at 0.
module perf_counter_table_unit #(
  parameter int unsigned ENTRY_COUNT = pct_pkg::DEF_ENTRY_COUNT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pct_in_if.sink    in_i,
  pct_out_if.source out_o
);
  import pct_pkg::*;

  pct_cmd_t  cmd;
  pct_stat_t stat;
  result_t   res;

  pct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pct_dp #(
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .func_i        (in_i.func),
    .entry_index_i (in_i.entry_index),
    .cycles_i      (in_i.measured_cycles),
    .res_o         (res)
  );

  assign out_o.assigned_index = res.assigned_index;
  assign out_o.entry_used     = res.entry_used;
  assign out_o.calls          = res.calls;
  assign out_o.cycle_sum      = res.cycle_sum;
  assign out_o.fewest_cycles  = res.fewest_cycles;
  assign out_o.most_cycles    = res.most_cycles;
  assign out_o.latest_cycles  = res.latest_cycles;
  assign out_o.mean_cycles    = res.mean_cycles;

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("accepted a second item while one is in flight");

  a_alloc_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.assigned_index != 8'd0 |-> !out_o.entry_used && out_o.calls == '0)
    else $error("allocate result carries read fields");

  a_used_has_calls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.entry_used |-> out_o.calls != '0)
    else $error("entry marked used without calls");

  a_mean_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.calls == '0 |-> out_o.mean_cycles == '0)
    else $error("nonzero mean with zero calls");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import pct_pkg::*;

  localparam int unsigned ENTRIES     = DEF_ENTRY_COUNT;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned PHASE_ITEMS = 340;
  localparam int unsigned MAX_PRINTED = 40;
  localparam int unsigned TAIL_CYCLES = 20;

  logic clk;
  logic rst_n;

  pct_in_if  in_if ();
  pct_out_if out_if ();

  perf_counter_table_unit u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // shadow copy of the counter bank
  logic [CYC_W-1:0] bank_calls  [ENTRIES];
  logic [CYC_W-1:0] bank_sum    [ENTRIES];
  logic [CYC_W-1:0] bank_least  [ENTRIES];
  logic [CYC_W-1:0] bank_most   [ENTRIES];
  logic [CYC_W-1:0] bank_latest [ENTRIES];
  int unsigned      bank_alloc_next;

  result_t     bank_replies_q[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  always #5 clk = ~clk;

  function automatic void bank_clear();
    for (int i = 0; i < ENTRIES; i++) begin
      bank_calls[i]  = '0;
      bank_sum[i]    = '0;
      bank_least[i]  = '1;
      bank_most[i]   = '0;
      bank_latest[i] = '0;
    end
    bank_alloc_next = 0;
  endfunction

  // Applies one operation to the shadow bank and returns the reply it produces.
  function automatic result_t bank_apply_op(func_e op, logic [IDX_IN_W-1:0] idx_in,
                                            logic [CYC_W-1:0] cyc);
    result_t     r;
    int unsigned idx;
    r   = '0;
    idx = idx_in % ENTRIES;
    case (op)
      FUNC_RECORD: begin
        bank_calls[idx]  = bank_calls[idx] + 1'b1;
        bank_sum[idx]    = bank_sum[idx] + cyc;
        bank_latest[idx] = cyc;
        if (cyc < bank_least[idx]) bank_least[idx] = cyc;
        if (cyc > bank_most[idx]) bank_most[idx] = cyc;
      end
      FUNC_ALLOC: begin
        if (bank_alloc_next >= ENTRIES) begin
          r.assigned_index = IDX_IN_W'(ENTRIES - 1);
        end else begin
          r.assigned_index = IDX_IN_W'(bank_alloc_next);
          bank_alloc_next++;
        end
      end
      FUNC_READ: begin
        r.entry_used    = (idx < bank_alloc_next) && (bank_calls[idx] != '0);
        r.calls         = bank_calls[idx];
        r.cycle_sum     = bank_sum[idx];
        r.fewest_cycles = bank_least[idx];
        r.most_cycles   = bank_most[idx];
        r.latest_cycles = bank_latest[idx];
        r.mean_cycles   = (bank_calls[idx] != '0) ? bank_sum[idx] / bank_calls[idx] : '0;
      end
      default: begin
        bank_clear();
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic check_field(string name, logic [CYC_W-1:0] got, logic [CYC_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // Holds valid across back-to-back items; only drops it for an idle gap.
  task automatic send_item(func_e op, logic [IDX_IN_W-1:0] idx, logic [CYC_W-1:0] cyc);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.valid           <= 1'b1;
    in_if.func            <= op;
    in_if.entry_index     <= idx;
    in_if.measured_cycles <= cyc;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    bank_replies_q.insert(bank_replies_q.size(), bank_apply_op(op, idx, cyc));
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (bank_replies_q.size() != 0);
  endtask

  function automatic logic [CYC_W-1:0] pick_cycles();
    case ($urandom_range(4))
      0:       return CYC_W'($urandom_range(1000));
      1:       return {$urandom, $urandom};
      2:       return '1 - CYC_W'($urandom_range(1000));
      3:       return CYC_W'(1) << $urandom_range(CYC_W - 1);
      default: return {$urandom, $urandom} >> $urandom_range(CYC_W - 1);
    endcase
  endfunction

  function automatic logic [IDX_IN_W-1:0] pick_index();
    case ($urandom_range(2))
      0:       return IDX_IN_W'($urandom_range(7));
      // straddle the allocator boundary so entry_used flips
      1:       return IDX_IN_W'(bank_alloc_next + $urandom_range(3) - 2);
      default: return IDX_IN_W'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_item(FUNC_READ, 8'd0, '0);
    send_item(FUNC_READ, 8'd255, '1);
    send_item(FUNC_RECORD, 8'd0, '0);
    send_item(FUNC_RECORD, 8'd0, '1);
    send_item(FUNC_READ, 8'd0, '0);
    send_item(FUNC_ALLOC, 8'd0, '0);
    send_item(FUNC_READ, 8'd0, '0);
    // sum on entry 255 wraps past 2^64
    send_item(FUNC_RECORD, 8'd255, '1);
    send_item(FUNC_RECORD, 8'd255, '1);
    send_item(FUNC_RECORD, 8'd255, 64'd5);
    send_item(FUNC_READ, 8'd255, '0);
    send_item(FUNC_RECORD, 8'd128, 64'h8000_0000_0000_0000);
    send_item(FUNC_READ, 8'd128, '0);
    send_item(FUNC_ALLOC, 8'hFF, '1);
    send_item(FUNC_READ, 8'd1, '0);
    send_item(FUNC_RECORD, 8'd1, 64'd7);
    send_item(FUNC_RECORD, 8'd1, 64'd3);
    send_item(FUNC_RECORD, 8'd1, 64'd9);
    send_item(FUNC_READ, 8'd1, '0);
    send_item(FUNC_CLEAR, 8'd0, '0);
    send_item(FUNC_READ, 8'd0, '0);
    send_item(FUNC_READ, 8'd255, '0);
    send_item(FUNC_ALLOC, 8'd0, '0);
    send_item(FUNC_READ, 8'd0, '0);
  endtask

  task automatic test_alloc_exhaustion();
    send_item(FUNC_CLEAR, IDX_IN_W'($urandom), pick_cycles());
    send_item(FUNC_RECORD, 8'd254, 64'd40);
    send_item(FUNC_RECORD, 8'd255, 64'd41);
    for (int i = 0; i < ENTRIES + 3; i++) begin
      send_item(FUNC_ALLOC, IDX_IN_W'($urandom), pick_cycles());
      if (i == ENTRIES - 2) send_item(FUNC_READ, 8'd255, '0);
    end
    send_item(FUNC_READ, 8'd254, '0);
    send_item(FUNC_READ, 8'd255, '0);
    send_item(FUNC_READ, 8'd3, '0);
  endtask

  // Mostly records and reads on a few busy entries, some allocates, rare clears.
  task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_pct);
    int unsigned roll;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      roll = $urandom_range(99);
      if (roll < 55) send_item(FUNC_RECORD, pick_index(), pick_cycles());
      else if (roll < 85) send_item(FUNC_READ, pick_index(), pick_cycles());
      else if (roll < 98) send_item(FUNC_ALLOC, IDX_IN_W'($urandom), pick_cycles());
      else send_item(FUNC_CLEAR, IDX_IN_W'($urandom), pick_cycles());
      if ($urandom_range(99) == 0) wait_drained();
    end
    wait_drained();
  endtask

  always @(posedge clk) begin : result_monitor
    result_t want;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (bank_replies_q.size() == 0) begin
        report_mismatch("result with nothing pending");
      end else begin
        want = bank_replies_q.pop_front();
        check_field("assigned_index", out_if.assigned_index, want.assigned_index);
        check_field("entry_used", out_if.entry_used, want.entry_used);
        check_field("calls", out_if.calls, want.calls);
        check_field("cycle_sum", out_if.cycle_sum, want.cycle_sum);
        check_field("fewest_cycles", out_if.fewest_cycles, want.fewest_cycles);
        check_field("most_cycles", out_if.most_cycles, want.most_cycles);
        check_field("latest_cycles", out_if.latest_cycles, want.latest_cycles);
        check_field("mean_cycles", out_if.mean_cycles, want.mean_cycles);
      end
    end
    out_if.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               bank_replies_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    clk                   = 1'b0;
    rst_n                 = 1'b0;
    in_if.valid           = 1'b0;
    in_if.func            = FUNC_RECORD;
    in_if.entry_index     = '0;
    in_if.measured_cycles = '0;
    out_if.ready          = 1'b0;
    mismatch_count        = 0;
    cycle_count           = 0;
    send_idle_pct         = 0;
    recv_stall_pct        = 0;
    bank_clear();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    wait_drained();
    send_idle_pct  = 27;
    recv_stall_pct = 27;
    test_alloc_exhaustion();
    wait_drained();
    test_random_traffic(0, 0);
    test_random_traffic(80, 0);
    test_random_traffic(0, 80);
    test_random_traffic(27, 27);

    // every item yields one result; the tail catches any extra ones
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
